>>> rtl/deb_pkg.sv
// ----------------------------------------------------------------------------
// deb_pkg: shared types and codes of the event buffer unpacker
// Result status codes, category codes, the classified word record and the
// sizing of the queue between the front and the back part.
// ----------------------------------------------------------------------------
package deb_pkg;

	// Result status codes
	localparam logic [2:0] ST_DATA         = 3'd0;
	localparam logic [2:0] ST_HEADER       = 3'd1;
	localparam logic [2:0] ST_EOB          = 3'd2;
	localparam logic [2:0] ST_BAD          = 3'd3;
	localparam logic [2:0] ST_HDR_IN_EVENT = 3'd4;
	localparam logic [2:0] ST_UNKNOWN_BOX  = 3'd5;
	localparam logic [2:0] ST_IGNORED      = 3'd6;

	// Detector categories
	localparam logic [2:0] KIND_NIM       = 3'd0;
	localparam logic [2:0] KIND_SCALER    = 3'd1;
	localparam logic [2:0] KIND_NAI_TIME  = 3'd2;
	localparam logic [2:0] KIND_GE_TIME   = 3'd3;
	localparam logic [2:0] KIND_NAI_E     = 3'd4;
	localparam logic [2:0] KIND_GE_E      = 3'd5;
	localparam logic [2:0] KIND_E         = 3'd6;
	localparam logic [2:0] KIND_DE        = 3'd7;
	localparam int         NUM_KINDS      = 8;

	// Register map
	localparam logic REG_BUFFER_WORDS = 1'b0;
	localparam logic [15:0] BUFFER_WORDS_RESET = 16'd8192;

	// Queue between front and back
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

	// One classified request
	typedef struct packed {
		logic        new_buffer; // start of a new buffer, no result
		logic        is_header;  // bits 31:30 both set
		logic        top_set;    // bit 31 or bit 30 set
		logic        eob_word;   // end-of-buffer marker word
		logic        box_known;  // box found in the category table
		logic [2:0]  kind;
		logic [7:0]  channel;    // already offset for the extra de box
		logic [15:0] value;
		logic [7:0]  length;     // data word count of a header
	} deb_item_t;

endpackage

>>> rtl/deb_front.sv
// ----------------------------------------------------------------------------
// deb_front: word classifier
// Decodes each accepted request into a classified record: marker bits, box
// category lookup, channel offset, value and header length.
// ----------------------------------------------------------------------------
module deb_front (
	input  logic               op,
	input  logic [31:0]        word,
	output deb_pkg::deb_item_t item
);
	import deb_pkg::*;

	localparam logic [6:0] BOX_DE_HIGH = 7'h23;

	logic [6:0] box;
	logic       known;
	logic [2:0] kind_code;

	// Box to category table
	always_comb begin
		known     = 1'b1;
		kind_code = KIND_NIM;
		case (box)
			7'h00, 7'h01: kind_code = KIND_NIM;
			7'h02:        kind_code = KIND_SCALER;
			7'h10:        kind_code = KIND_NAI_TIME;
			7'h11:        kind_code = KIND_GE_TIME;
			7'h20, 7'h24: kind_code = KIND_NAI_E;
			7'h25:        kind_code = KIND_GE_E;
			7'h21:        kind_code = KIND_E;
			7'h22, 7'h23: kind_code = KIND_DE;
			default:      known     = 1'b0;
		endcase
	end

	assign box = word[29:23];

	// Record fields
	always_comb begin
		item.new_buffer = op;
		item.is_header  = word[31] & word[30];
		item.top_set    = word[31] | word[30];
		item.eob_word   = (word == 32'h8000_0000);
		item.box_known  = known;
		item.kind       = kind_code;
		item.channel    = {1'b0, word[22:16]} + ((box == BOX_DE_HIGH) ? 8'd32 : 8'd0);
		item.value      = word[15:0];
		item.length     = word[7:0];
	end

endmodule

>>> rtl/deb_queue.sv
// ----------------------------------------------------------------------------
// deb_queue: request queue
// Small FIFO of classified requests between the front and the back part,
// so that either side may stall without holding the other.
// ----------------------------------------------------------------------------
module deb_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push_valid,
	output logic               push_ready,
	input  deb_pkg::deb_item_t push_item,
	output logic               pop_valid,
	input  logic               pop_ready,
	output deb_pkg::deb_item_t pop_item
);
	import deb_pkg::*;

	deb_item_t             mem_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0]   wr_ptr_q;
	logic [QUEUE_AW-1:0]   rd_ptr_q;
	logic [QUEUE_AW:0]     count_q;
	logic                  do_push;
	logic                  do_pop;

	assign push_ready = (count_q != (QUEUE_AW+1)'(QUEUE_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_item   = mem_q[rd_ptr_q];
	assign do_push    = push_valid & push_ready;
	assign do_pop     = pop_valid & pop_ready;

	// Storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

>>> rtl/deb_back.sv
// ----------------------------------------------------------------------------
// deb_back: event sequencer
// Applies the buffer and event state to each classified request: phase,
// words left, buffer position and category slot counters. Results go to an
// output register.
// ----------------------------------------------------------------------------
module deb_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [15:0]        buffer_words,
	input  logic               head_valid,
	output logic               head_ready,
	input  deb_pkg::deb_item_t head,
	output logic               result_valid,
	input  logic               result_ready,
	output logic [2:0]         status,
	output logic [2:0]         kind,
	output logic [7:0]         channel,
	output logic [15:0]        value,
	output logic [7:0]         slot,
	output logic [7:0]         event_length,
	output logic               event_last
);
	import deb_pkg::*;

	localparam logic [1:0] PH_HEADER = 2'd0;
	localparam logic [1:0] PH_EVENT  = 2'd1;
	localparam logic [1:0] PH_IGNORE = 2'd2;

	logic [1:0]  phase_q;
	logic [7:0]  words_left_q;
	logic [15:0] position_q;
	logic [7:0]  cat_q [NUM_KINDS];

	logic        out_valid_q;
	logic [2:0]  status_q;
	logic [2:0]  kind_q;
	logic [7:0]  channel_q;
	logic [15:0] value_q;
	logic [7:0]  slot_q;
	logic [7:0]  length_q;
	logic        last_q;

	logic        pop;
	logic [1:0]  phase_d;
	logic [7:0]  words_left_d;
	logic        adv_pos;
	logic        clr_cats;
	logic        inc_cat;
	logic [7:0]  left_dec;
	logic [2:0]  st_d;
	logic        last_d;
	logic        hdr_d;
	logic        data_d;

	// A request leaves the queue when the output register can take a result
	assign head_ready = ~out_valid_q | result_ready;
	assign pop        = head_valid & head_ready;
	assign left_dec   = words_left_q - 8'd1;

	// Next state and result of the head request
	always_comb begin
		phase_d      = phase_q;
		words_left_d = words_left_q;
		adv_pos      = 1'b0;
		clr_cats     = 1'b0;
		inc_cat      = 1'b0;
		st_d         = ST_IGNORED;
		last_d       = 1'b0;
		hdr_d        = 1'b0;
		data_d       = 1'b0;
		unique case (phase_q)
			PH_HEADER: begin
				if (position_q >= buffer_words) begin
					st_d    = ST_EOB;
					phase_d = PH_IGNORE;
				end else if (!head.is_header) begin
					st_d    = head.eob_word ? ST_EOB : ST_BAD;
					phase_d = PH_IGNORE;
				end else begin
					st_d     = ST_HEADER;
					hdr_d    = 1'b1;
					clr_cats = 1'b1;
					adv_pos  = 1'b1;
					if (head.length == 8'd0) begin
						last_d = 1'b1;
					end else begin
						words_left_d = head.length;
						phase_d      = PH_EVENT;
					end
				end
			end
			PH_EVENT: begin
				if (head.top_set) begin
					st_d    = ST_HDR_IN_EVENT;
					phase_d = PH_IGNORE;
				end else if (!head.box_known) begin
					st_d    = ST_UNKNOWN_BOX;
					phase_d = PH_IGNORE;
				end else begin
					st_d         = ST_DATA;
					data_d       = 1'b1;
					inc_cat      = 1'b1;
					adv_pos      = 1'b1;
					words_left_d = left_dec;
					if (left_dec == 8'd0) begin
						last_d  = 1'b1;
						phase_d = PH_HEADER;
					end
				end
			end
			default: begin
				st_d = ST_IGNORED;
			end
		endcase
	end

	// Buffer and event state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_HEADER;
			words_left_q <= '0;
			position_q   <= '0;
			for (int i = 0; i < NUM_KINDS; i++) begin
				cat_q[i] <= '0;
			end
		end else if (pop) begin
			if (head.new_buffer) begin
				phase_q      <= PH_HEADER;
				words_left_q <= '0;
				position_q   <= '0;
			end else begin
				phase_q      <= phase_d;
				words_left_q <= words_left_d;
				if (adv_pos && position_q != 16'hFFFF) begin
					position_q <= position_q + 16'd1;
				end
				if (clr_cats) begin
					for (int i = 0; i < NUM_KINDS; i++) begin
						cat_q[i] <= '0;
					end
				end else if (inc_cat) begin
					cat_q[head.kind] <= cat_q[head.kind] + 8'd1;
				end
			end
		end
	end

	// Output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop && !head.new_buffer) begin
			out_valid_q <= 1'b1;
		end else if (result_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (pop && !head.new_buffer) begin
			status_q  <= st_d;
			kind_q    <= data_d ? head.kind : 3'd0;
			channel_q <= data_d ? head.channel : 8'd0;
			value_q   <= data_d ? head.value : 16'd0;
			slot_q    <= data_d ? cat_q[head.kind] : 8'd0;
			length_q  <= hdr_d ? head.length : 8'd0;
			last_q    <= last_d;
		end
	end

	assign result_valid = out_valid_q;
	assign status       = status_q;
	assign kind         = kind_q;
	assign channel      = channel_q;
	assign value        = value_q;
	assign slot         = slot_q;
	assign event_length = length_q;
	assign event_last   = last_q;

endmodule

>>> rtl/daq_event_buffer_unpacker.sv
// ----------------------------------------------------------------------------
// daq_event_buffer_unpacker: data-acquisition buffer word unpacker
// Splits a stream of buffer words into headers and categorized data entries.
//
// Usage:
//   Input channel (word_valid/word_ready, op, word): one request per buffer
//   word; op = 1 starts a new buffer and produces no result.
//   Result channel (result_valid/result_ready): one result per buffer word
//   with status, kind, channel, value, slot, event_length and event_last.
//   APB port: register 0 at address 0 is buffer_words (reset 8192).
//   Throughput: one word per cycle sustained while result_ready is high.
//   An accepted word is written into the four-entry request queue and
//   then registered in a single output register, where its result shows.
//   When the receiver stalls, the queue fills and word_ready drops
//   once it holds four words. Reset clears the queue, the output register
//   and the event state; the block is then waiting for a header.
// ----------------------------------------------------------------------------
module daq_event_buffer_unpacker (
	input  logic        clk,
	input  logic        arst_n,
	// input requests
	input  logic        word_valid,
	output logic        word_ready,
	input  logic        op,
	input  logic [31:0] word,
	// results
	output logic        result_valid,
	input  logic        result_ready,
	output logic [2:0]  status,
	output logic [2:0]  kind,
	output logic [7:0]  channel,
	output logic [15:0] value,
	output logic [7:0]  slot,
	output logic [7:0]  event_length,
	output logic        event_last,
	// configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import deb_pkg::*;

	deb_item_t   front_item;
	deb_item_t   head_item;
	logic        head_valid;
	logic        head_ready;
	logic [15:0] buffer_words_q;
	logic        reg_sel;

	// Register file
	assign pready  = 1'b1;
	assign reg_sel = paddr[2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buffer_words_q <= BUFFER_WORDS_RESET;
		end else if (psel && penable && pwrite && reg_sel == REG_BUFFER_WORDS) begin
			buffer_words_q <= pwdata[15:0];
		end
	end

	assign prdata = (reg_sel == REG_BUFFER_WORDS) ? {16'd0, buffer_words_q} : 32'd0;

	// Classifier
	deb_front u_front (
		.op   (op),
		.word (word),
		.item (front_item)
	);

	// Request queue
	deb_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (word_valid),
		.push_ready (word_ready),
		.push_item  (front_item),
		.pop_valid  (head_valid),
		.pop_ready  (head_ready),
		.pop_item   (head_item)
	);

	// Event sequencer and output register
	deb_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.buffer_words (buffer_words_q),
		.head_valid   (head_valid),
		.head_ready   (head_ready),
		.head         (head_item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.status       (status),
		.kind         (kind),
		.channel      (channel),
		.value        (value),
		.slot         (slot),
		.event_length (event_length),
		.event_last   (event_last)
	);

	// Data fields only carry content on data results
	a_data_fields_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && status != ST_DATA |->
		kind == 3'd0 && channel == 8'd0 && value == 16'd0 && slot == 8'd0)
		else $error("data fields set on a non-data result");

	// Event end flag only on data words and headers
	a_last_kind: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && event_last |-> status == ST_DATA || status == ST_HEADER)
		else $error("event_last on a result that cannot end an event");

	// Header length only on headers
	a_length_header: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && event_length != 8'd0 |-> status == ST_HEADER)
		else $error("event_length set on a non-header result");

endmodule
